// File: rtl/lps_pkg.sv
// Shared codes and types for the luma plane cube slice block.
package lps_pkg;

  // Which component of a corner comes from the scaled product.
  localparam logic [1:0] SEL_R    = 2'd0;
  localparam logic [1:0] SEL_G    = 2'd1;
  localparam logic [1:0] SEL_B    = 2'd2;
  localparam logic [1:0] SEL_NONE = 2'd3;

  // Configuration register indexes.
  localparam logic [2:0] CFG_W_RED   = 3'd0;
  localparam logic [2:0] CFG_W_GREEN = 3'd1;
  localparam logic [2:0] CFG_W_BLUE  = 3'd2;
  localparam logic [2:0] CFG_R_RED   = 3'd3;
  localparam logic [2:0] CFG_R_GREEN = 3'd4;
  localparam logic [2:0] CFG_R_BLUE  = 3'd5;

  typedef struct packed {
    logic       oor;
    logic [2:0] n;
  } item_t;

endpackage

// File: rtl/lps_sel.sv
// Stage 1: pick the corner formulas and form the level differences.
module lps_sel #(
  parameter int F = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    i_valid,
  output logic                    i_ready,
  input  logic [F:0]              z,
  input  logic [F-1:0]            wr,
  input  logic [F-1:0]            wg,
  input  logic [F-1:0]            wb,
  input  logic [F+7:0]            rr,
  input  logic [F+7:0]            rg,
  input  logic [F+7:0]            rb,
  output logic                    o_valid,
  input  logic                    o_ready,
  output lps_pkg::item_t          o_item,
  output logic [4:0][1:0]         o_sel,
  output logic [4:0][2:0]         o_one,
  output logic [4:0][F:0]         o_d,
  output logic [4:0][F+7:0]       o_rc
);
  localparam int DW = F + 3;
  localparam logic [DW-1:0] ONE_V = DW'(1) << F;

  logic [DW-1:0]          zs, xr, xg, xb, srb, srg, sgb;
  logic [4:0][1:0]        sel_c;
  logic [4:0][2:0]        one_c;
  logic [4:0][DW-1:0]     d_c;
  logic [4:0][F+7:0]      rc_c;
  logic [4:0][F:0]        dp_c;
  lps_pkg::item_t         item_c;
  logic                   valid_r;
  lps_pkg::item_t         item_r;
  logic [4:0][1:0]        sel_r;
  logic [4:0][2:0]        one_r;
  logic [4:0][F:0]        d_r;
  logic [4:0][F+7:0]      rc_r;

  assign zs  = DW'(z);
  assign xr  = DW'(wr);
  assign xg  = DW'(wg);
  assign xb  = DW'(wb);
  assign srb = xr + xb;
  assign srg = xr + xg;
  assign sgb = xg + xb;

  always_comb begin
    item_c.oor = 1'b0;
    item_c.n   = 3'd1;
    for (int k = 0; k < 5; k++) begin
      sel_c[k] = lps_pkg::SEL_NONE;
      one_c[k] = 3'b000;
      d_c[k]   = '0;
      rc_c[k]  = '0;
    end
    if (zs > ONE_V) begin
      item_c.oor = 1'b1;
    end else if (zs == '0) begin
      item_c.n = 3'd1;
    end else if (zs <= xb) begin
      item_c.n = 3'd3;
      sel_c[0] = lps_pkg::SEL_R; d_c[0] = zs; rc_c[0] = rr;
      sel_c[1] = lps_pkg::SEL_G; d_c[1] = zs; rc_c[1] = rg;
      sel_c[2] = lps_pkg::SEL_B; d_c[2] = zs; rc_c[2] = rb;
    end else if (zs <= xr) begin
      item_c.n = 3'd4;
      sel_c[0] = lps_pkg::SEL_R; d_c[0] = zs; rc_c[0] = rr;
      sel_c[1] = lps_pkg::SEL_G; d_c[1] = zs; rc_c[1] = rg;
      sel_c[2] = lps_pkg::SEL_G; one_c[2] = 3'b001; d_c[2] = zs - xb; rc_c[2] = rg;
      sel_c[3] = lps_pkg::SEL_R; one_c[3] = 3'b001; d_c[3] = zs - xb; rc_c[3] = rr;
    end else if (zs < srb) begin
      item_c.n = 3'd5;
      sel_c[0] = lps_pkg::SEL_G; one_c[0] = 3'b100; d_c[0] = zs - xr; rc_c[0] = rg;
      sel_c[1] = lps_pkg::SEL_G; d_c[1] = zs; rc_c[1] = rg;
      sel_c[2] = lps_pkg::SEL_G; one_c[2] = 3'b001; d_c[2] = zs - xb; rc_c[2] = rg;
      sel_c[3] = lps_pkg::SEL_R; one_c[3] = 3'b001; d_c[3] = zs - xb; rc_c[3] = rr;
      sel_c[4] = lps_pkg::SEL_B; one_c[4] = 3'b100; d_c[4] = zs - xr; rc_c[4] = rb;
    end else if (zs <= xg) begin
      item_c.n = 3'd4;
      sel_c[0] = lps_pkg::SEL_G; one_c[0] = 3'b100; d_c[0] = zs - xr; rc_c[0] = rg;
      sel_c[1] = lps_pkg::SEL_G; d_c[1] = zs; rc_c[1] = rg;
      sel_c[2] = lps_pkg::SEL_G; one_c[2] = 3'b001; d_c[2] = zs - xb; rc_c[2] = rg;
      sel_c[3] = lps_pkg::SEL_G; one_c[3] = 3'b101; d_c[3] = zs - srb; rc_c[3] = rg;
    end else if (zs < sgb) begin
      item_c.n = 3'd5;
      sel_c[0] = lps_pkg::SEL_G; one_c[0] = 3'b100; d_c[0] = zs - xr; rc_c[0] = rg;
      sel_c[1] = lps_pkg::SEL_R; one_c[1] = 3'b010; d_c[1] = zs - xg; rc_c[1] = rr;
      sel_c[2] = lps_pkg::SEL_B; one_c[2] = 3'b010; d_c[2] = zs - xg; rc_c[2] = rb;
      sel_c[3] = lps_pkg::SEL_G; one_c[3] = 3'b001; d_c[3] = zs - xb; rc_c[3] = rg;
      sel_c[4] = lps_pkg::SEL_G; one_c[4] = 3'b101; d_c[4] = zs - srb; rc_c[4] = rg;
    end else if (zs < srg) begin
      item_c.n = 3'd4;
      sel_c[0] = lps_pkg::SEL_R; one_c[0] = 3'b010; d_c[0] = zs - xg; rc_c[0] = rr;
      sel_c[1] = lps_pkg::SEL_G; one_c[1] = 3'b100; d_c[1] = zs - xr; rc_c[1] = rg;
      sel_c[2] = lps_pkg::SEL_R; one_c[2] = 3'b011; d_c[2] = zs - sgb; rc_c[2] = rr;
      sel_c[3] = lps_pkg::SEL_G; one_c[3] = 3'b101; d_c[3] = zs - srb; rc_c[3] = rg;
    end else if (zs < ONE_V) begin
      item_c.n = 3'd3;
      sel_c[0] = lps_pkg::SEL_R; one_c[0] = 3'b011; d_c[0] = zs - sgb; rc_c[0] = rr;
      sel_c[1] = lps_pkg::SEL_G; one_c[1] = 3'b101; d_c[1] = zs - srb; rc_c[1] = rg;
      sel_c[2] = lps_pkg::SEL_B; one_c[2] = 3'b110; d_c[2] = zs - srg; rc_c[2] = rb;
    end else begin
      one_c[0] = 3'b111;
    end
  end

  // A difference of zero or below scales to zero.
  always_comb begin
    for (int k = 0; k < 5; k++) begin
      dp_c[k] = (!d_c[k][DW-1] && d_c[k] != '0) ? d_c[k][F:0] : '0;
    end
  end

  assign i_ready = !valid_r || o_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (i_ready) begin
      valid_r <= i_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (i_valid && i_ready) begin
      item_r <= item_c;
      sel_r  <= sel_c;
      one_r  <= one_c;
      d_r    <= dp_c;
      rc_r   <= rc_c;
    end
  end

  assign o_valid = valid_r;
  assign o_item  = item_r;
  assign o_sel   = sel_r;
  assign o_one   = one_r;
  assign o_d     = d_r;
  assign o_rc    = rc_r;
endmodule

// File: rtl/lps_mul.sv
// Stages 2 and 3: multiply by reciprocals, then round, saturate and build corners.
module lps_mul #(
  parameter int F = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    i_valid,
  output logic                    i_ready,
  input  lps_pkg::item_t          i_item,
  input  logic [4:0][1:0]         i_sel,
  input  logic [4:0][2:0]         i_one,
  input  logic [4:0][F:0]         i_d,
  input  logic [4:0][F+7:0]       i_rc,
  output logic                    o_valid,
  input  logic                    o_ready,
  output lps_pkg::item_t          o_item,
  output logic [4:0][2:0][F:0]    o_comp
);
  localparam int PW = 2 * F + 9;
  localparam logic [PW:0] HALF_V = (PW+1)'(1) << (F - 1);
  localparam logic [PW:0] ONE_W  = (PW+1)'(1) << F;
  localparam logic [F:0]  ONE_V  = (F+1)'(1) << F;

  logic                   va_r, vb_r, ready_a, ready_b;
  lps_pkg::item_t         item_a_r, item_b_r;
  logic [4:0][1:0]        sel_a_r;
  logic [4:0][2:0]        one_a_r;
  logic [4:0][PW-1:0]     prod_a_r;
  logic [4:0][PW:0]       q_c;
  logic [4:0][F:0]        qs_c;
  logic [4:0][2:0][F:0]   comp_c;
  logic [4:0][2:0][F:0]   comp_b_r;

  assign ready_b = !vb_r || o_ready;
  assign ready_a = !va_r || ready_b;
  assign i_ready = ready_a;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      if (ready_a) va_r <= i_valid;
      if (ready_b) vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (i_valid && ready_a) begin
      item_a_r <= i_item;
      sel_a_r  <= i_sel;
      one_a_r  <= i_one;
      for (int k = 0; k < 5; k++) begin
        prod_a_r[k] <= PW'(i_d[k]) * PW'(i_rc[k]);
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 5; k++) begin
      q_c[k]  = ({1'b0, prod_a_r[k]} + HALF_V) >> F;
      qs_c[k] = (q_c[k] > ONE_W) ? ONE_V : q_c[k][F:0];
      comp_c[k][0] = one_a_r[k][2] ? ONE_V :
                     (sel_a_r[k] == lps_pkg::SEL_R) ? qs_c[k] : '0;
      comp_c[k][1] = one_a_r[k][1] ? ONE_V :
                     (sel_a_r[k] == lps_pkg::SEL_G) ? qs_c[k] : '0;
      comp_c[k][2] = one_a_r[k][0] ? ONE_V :
                     (sel_a_r[k] == lps_pkg::SEL_B) ? qs_c[k] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (va_r && ready_b) begin
      item_b_r <= item_a_r;
      comp_b_r <= comp_c;
    end
  end

  assign o_valid = vb_r;
  assign o_item  = item_b_r;
  assign o_comp  = comp_b_r;
endmodule

// File: rtl/lps_ser.sv
// Stage 4: drop repeated corners and send the kept ones one transfer at a time.
module lps_ser #(
  parameter int F = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    i_valid,
  output logic                    i_ready,
  input  lps_pkg::item_t          i_item,
  input  logic [4:0][2:0][F:0]    i_comp,
  output logic                    o_valid,
  input  logic                    o_ready,
  output logic [F:0]              o_red,
  output logic [F:0]              o_green,
  output logic [F:0]              o_blue,
  output logic [2:0]              o_count,
  output logic                    o_last,
  output logic                    o_oor
);
  logic [4:0][2:0][F:0]   cc_c;
  logic [2:0]             m_c;
  logic [4:0][2:0][F:0]   buf_r;
  logic [2:0]             cnt_r, idx_r;
  logic                   oor_r, bvalid_r, last_c;

  // Compare each corner with its neighbor; a dropped one equals the last kept.
  always_comb begin
    cc_c    = '0;
    m_c     = 3'd1;
    cc_c[0] = i_item.oor ? '0 : i_comp[0];
    if (!i_item.oor) begin
      for (int k = 1; k < 5; k++) begin
        if (3'(k) < i_item.n && i_comp[k] != i_comp[k-1]) begin
          cc_c[m_c[2:0]] = i_comp[k];
          m_c = m_c + 3'd1;
        end
      end
    end
    if (m_c == 3'd2) m_c = 3'd1;
  end

  assign last_c  = (idx_r == cnt_r - 3'd1);
  assign i_ready = !bvalid_r || (o_ready && last_c);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bvalid_r <= 1'b0;
      idx_r    <= 3'd0;
    end else if (i_ready) begin
      bvalid_r <= i_valid;
      idx_r    <= 3'd0;
    end else if (o_ready) begin
      idx_r <= idx_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (i_valid && i_ready) begin
      buf_r <= cc_c;
      cnt_r <= m_c;
      oor_r <= i_item.oor;
    end
  end

  assign o_valid = bvalid_r;
  assign o_red   = buf_r[idx_r][0];
  assign o_green = buf_r[idx_r][1];
  assign o_blue  = buf_r[idx_r][2];
  assign o_count = oor_r ? 3'd0 : cnt_r;
  assign o_last  = last_c;
  assign o_oor   = oor_r;
endmodule

// File: rtl/luma_plane_rgb_cube_slice_core.sv
// Top level of the luma plane cube slice block.
//
//  channel | ports                                   | direction
//  input   | in_valid, in_ready, in_z_level          | item in
//  result  | out_valid, out_ready, out_red..out_of.. | corner out
//  config  | cfg_valid, cfg_ready, cfg_index, cfg_data | register write
//
// Four register stages: select, multiply, round/saturate, dedupe buffer.
// Each item gives one to five results, one transfer per cycle while out_ready is high;
// the output buffer takes a new item only once the last result of the current one is taken.
// An item passes the select, multiply, round/saturate and buffer registers in that order.
// Reset clears all valid bits and loads the default weights and reciprocals.
// A stall at the output holds every stage that holds an item; nothing is lost or repeated.
module luma_plane_rgb_cube_slice_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [FRAC_BITS:0]   in_z_level,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [FRAC_BITS:0]   out_red,
  output logic [FRAC_BITS:0]   out_green,
  output logic [FRAC_BITS:0]   out_blue,
  output logic [2:0]           out_vertex_count,
  output logic                 out_last,
  output logic                 out_out_of_range,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [2:0]           cfg_index,
  input  logic [FRAC_BITS+7:0] cfg_data
);
  localparam int F = FRAC_BITS;
  localparam logic [F-1:0] WR_RST = (F >= 16) ? F'(19595 << (F - 16)) : F'(19595 >> (16 - F));
  localparam logic [F-1:0] WG_RST = (F >= 16) ? F'(38470 << (F - 16)) : F'(38470 >> (16 - F));
  localparam logic [F-1:0] WB_RST = (F >= 16) ? F'(7471 << (F - 16)) : F'(7471 >> (16 - F));
  localparam logic [F+7:0] RR_RST = (F >= 16) ? (F+8)'(219187 << (F - 16))
                                              : (F+8)'(219187 >> (16 - F));
  localparam logic [F+7:0] RG_RST = (F >= 16) ? (F+8)'(111645 << (F - 16))
                                              : (F+8)'(111645 >> (16 - F));
  localparam logic [F+7:0] RB_RST = (F >= 16) ? (F+8)'(574885 << (F - 16))
                                              : (F+8)'(574885 >> (16 - F));

  logic [F-1:0]          wr_r, wg_r, wb_r;
  logic [F+7:0]          rr_r, rg_r, rb_r;
  logic                  s1_valid, s1_ready, s3_valid, s3_ready;
  lps_pkg::item_t        s1_item, s3_item;
  logic [4:0][1:0]       s1_sel;
  logic [4:0][2:0]       s1_one;
  logic [4:0][F:0]       s1_d;
  logic [4:0][F+7:0]     s1_rc;
  logic [4:0][2:0][F:0]  s3_comp;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r <= WR_RST;
      wg_r <= WG_RST;
      wb_r <= WB_RST;
      rr_r <= RR_RST;
      rg_r <= RG_RST;
      rb_r <= RB_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        lps_pkg::CFG_W_RED:   wr_r <= cfg_data[F-1:0];
        lps_pkg::CFG_W_GREEN: wg_r <= cfg_data[F-1:0];
        lps_pkg::CFG_W_BLUE:  wb_r <= cfg_data[F-1:0];
        lps_pkg::CFG_R_RED:   rr_r <= cfg_data;
        lps_pkg::CFG_R_GREEN: rg_r <= cfg_data;
        lps_pkg::CFG_R_BLUE:  rb_r <= cfg_data;
        default: ;
      endcase
    end
  end

  lps_sel #(.F(F)) u_sel (
    .clk(clk), .rst_n(rst_n),
    .i_valid(in_valid), .i_ready(in_ready), .z(in_z_level),
    .wr(wr_r), .wg(wg_r), .wb(wb_r), .rr(rr_r), .rg(rg_r), .rb(rb_r),
    .o_valid(s1_valid), .o_ready(s1_ready), .o_item(s1_item),
    .o_sel(s1_sel), .o_one(s1_one), .o_d(s1_d), .o_rc(s1_rc)
  );

  lps_mul #(.F(F)) u_mul (
    .clk(clk), .rst_n(rst_n),
    .i_valid(s1_valid), .i_ready(s1_ready), .i_item(s1_item),
    .i_sel(s1_sel), .i_one(s1_one), .i_d(s1_d), .i_rc(s1_rc),
    .o_valid(s3_valid), .o_ready(s3_ready), .o_item(s3_item), .o_comp(s3_comp)
  );

  lps_ser #(.F(F)) u_ser (
    .clk(clk), .rst_n(rst_n),
    .i_valid(s3_valid), .i_ready(s3_ready), .i_item(s3_item), .i_comp(s3_comp),
    .o_valid(out_valid), .o_ready(out_ready),
    .o_red(out_red), .o_green(out_green), .o_blue(out_blue),
    .o_count(out_vertex_count), .o_last(out_last), .o_oor(out_out_of_range)
  );

  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_out_of_range |-> out_vertex_count == 3'd0 && out_last &&
      out_red == '0 && out_green == '0 && out_blue == '0)
    else $error("out of range result not blank");

  a_more_follow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> out_valid)
    else $error("item cut short");

  a_count_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_out_of_range |-> out_vertex_count != 3'd0 &&
      out_vertex_count != 3'd2 && out_vertex_count <= 3'd5)
    else $error("bad corner count");
endmodule
